[hw/rtl/sliding_window_deviation_defines.svh]
// assertion macros for the sliding window deviation block
// used by the port checker; expects clk and rst_n in the calling scope
`ifndef SLIDING_WINDOW_DEVIATION_DEFINES_SVH
`define SLIDING_WINDOW_DEVIATION_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SWD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SWD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/swd_pkg.sv]
// shared types and constants for the sliding window deviation block
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package swd_pkg;

    // field and state widths
    localparam int SAMPLE_W  = 12;
    localparam int VALUE_W   = 16;
    localparam int INDEX_W   = 12;
    localparam int LEN_W     = 8;
    localparam int SUM_W     = 20;
    localparam int SQ_SUM_W  = 32;
    localparam int SQ_W      = 24;
    localparam int MULB_W    = 21;
    localparam int ROOT_REM_W = 18;

    // port packing
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // window length after reset
    localparam logic [LEN_W-1:0] LEN_RESET = 8'd8;

    // last iteration index of the divider and the square root
    localparam int CNT_W      = 5;
    localparam logic [CNT_W-1:0] DIV_LAST  = 5'd19;
    localparam logic [CNT_W-1:0] ROOT_LAST = 5'd15;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_UPD_SQ,
        ST_UPD_ACC,
        ST_SW_RD,
        ST_SW_SQ,
        ST_SW_ACC,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_SUB,
        ST_ROOT,
        ST_OUT
    } swd_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic load;
        logic upd_sq;
        logic upd_acc;
        logic sw_rd;
        logic sw_sq;
        logic sw_acc;
        logic prep;
        logic div_step;
        logic mul_dev;
        logic sub;
        logic root_step;
        logic out_load;
    } swd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic resync;
        logic need_dev;
        logic sweep_last;
        logic out_full;
    } swd_status_t;

endpackage

`default_nettype wire

[hw/rtl/swd_ctrl.sv]
// sequencing state machine of the sliding window deviation block
// depends on swd_pkg; drives the datapath through swd_cmd_t
`default_nettype none

module swd_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire                  m_tready,
    input  swd_pkg::swd_status_t status,
    output swd_pkg::swd_cmd_t    cmd
);
    import swd_pkg::*;

    swd_state_t       state_reg;
    swd_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_free;

    assign out_free = !status.out_full || m_tready;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = status.resync ? ST_SW_RD : ST_UPD_SQ;
            end
            ST_UPD_SQ:
            begin
                state_next = ST_UPD_ACC;
            end
            ST_UPD_ACC:
            begin
                state_next = status.need_dev ? ST_PREP : ST_OUT;
            end
            ST_SW_RD:
            begin
                state_next = ST_SW_SQ;
            end
            ST_SW_SQ:
            begin
                state_next = ST_SW_ACC;
            end
            ST_SW_ACC:
            begin
                if (!status.sweep_last)
                    state_next = ST_SW_RD;
                else
                    state_next = status.need_dev ? ST_PREP : ST_OUT;
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                state_next = ST_ROOT;
                cnt_next   = '0;
            end
            ST_ROOT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ROOT_LAST)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_LOAD:    cmd.load      = 1'b1;
            ST_UPD_SQ:  cmd.upd_sq    = 1'b1;
            ST_UPD_ACC: cmd.upd_acc   = 1'b1;
            ST_SW_RD:   cmd.sw_rd     = 1'b1;
            ST_SW_SQ:   cmd.sw_sq     = 1'b1;
            ST_SW_ACC:  cmd.sw_acc    = 1'b1;
            ST_PREP:    cmd.prep      = 1'b1;
            ST_DIV:     cmd.div_step  = 1'b1;
            ST_MUL:     cmd.mul_dev   = 1'b1;
            ST_SUB:     cmd.sub       = 1'b1;
            ST_ROOT:    cmd.root_step = 1'b1;
            ST_OUT:     cmd.out_load  = out_free;
            default:    cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/swd_datapath.sv]
// datapath: sample ring, running sums, divider, shared multiplier, square root
// and output register; depends on swd_pkg, steered by swd_ctrl
`default_nettype none

module swd_datapath #(
    parameter int FRAME_PIXELS = 4096,
    parameter int MAX_WINDOW   = 256
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire  [swd_pkg::LEN_W-1:0]       cfg_wdata,
    input  wire  [swd_pkg::SAMPLE_W-1:0]    in_sample,
    input  wire                             in_frame_start,
    input  swd_pkg::swd_cmd_t               cmd,
    output swd_pkg::swd_status_t            status,
    input  wire                             m_tready,
    output logic                            out_valid,
    output logic [swd_pkg::VALUE_W-1:0]     out_value,
    output logic                            out_is_dev,
    output logic [swd_pkg::INDEX_W-1:0]     out_index,
    output logic                            out_last
);
    import swd_pkg::*;

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int XW = AW + 2;
    localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(FRAME_PIXELS - 1);
    localparam logic [XW-1:0]      DEPTH_X  = XW'(MAX_WINDOW);

    // configuration and control state
    logic [LEN_W-1:0]    window_len_reg;
    logic                resync_reg;
    logic [INDEX_W-1:0]  pixel_count_reg;
    logic [AW-1:0]       pos_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SQ_SUM_W-1:0] sq_sum_reg;
    logic                out_valid_reg;

    // per word payload
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic [AW-1:0]         cur_pos_reg;
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic [SQ_W-1:0]       sq_new_reg;
    logic [SQ_SUM_W-1:0]   prod_reg;
    logic [LEN_W-1:0]      k_reg;
    logic [LEN_W:0]        div_rem_reg;
    logic [SUM_W-1:0]      div_quo_reg;
    logic [SQ_SUM_W-1:0]   root_x_reg;
    logic [ROOT_REM_W-1:0] root_rem_reg;
    logic [VALUE_W-1:0]    root_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic                  out_is_dev_reg;
    logic [INDEX_W-1:0]    out_index_reg;
    logic                  out_last_reg;

    logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];

    logic [LEN_W:0]        len_wide;
    logic [LEN_W-1:0]      len_eff;
    logic [INDEX_W-1:0]    idx_in;
    logic [XW-1:0]         old_x;
    logic [XW-1:0]         sweep_x;
    logic [AW-1:0]         old_addr;
    logic [AW-1:0]         sweep_addr;
    logic [AW-1:0]         rd_addr;
    logic                  need_dev;
    logic                  drop_old;
    logic                  sweep_last;
    logic [SAMPLE_W-1:0]   mul_a;
    logic [MULB_W-1:0]     mul_b;
    logic [SQ_SUM_W-1:0]   mul_p;
    logic [LEN_W:0]        div_shift;
    logic                  div_bit;
    logic [ROOT_REM_W-1:0] rem_shift;
    logic [ROOT_REM_W-1:0] root_trial;
    logic                  root_bit;
    logic [SUM_W-1:0]      sum_base;
    logic [SQ_SUM_W-1:0]   sq_base;

    // effective window length: zero acts as one, clamp to ring depth
    always_comb
    begin
        len_wide = {1'b0, window_len_reg};
        if (window_len_reg == '0)
            len_wide = (LEN_W + 1)'(1);
        else if (len_wide > (LEN_W + 1)'(MAX_WINDOW))
            len_wide = (LEN_W + 1)'(MAX_WINDOW);
        len_eff = len_wide[LEN_W-1:0];
    end

    // index of the incoming word
    assign idx_in = in_frame_start ? '0 : pixel_count_reg;

    // ring addresses: oldest leaving entry and sweep entry, modulo depth
    always_comb
    begin
        old_x   = XW'(pos_reg) + DEPTH_X - XW'(len_eff);
        sweep_x = XW'(cur_pos_reg) + DEPTH_X - XW'(k_reg);
        old_addr   = (old_x >= DEPTH_X) ? AW'(old_x - DEPTH_X) : AW'(old_x);
        sweep_addr = (sweep_x >= DEPTH_X) ? AW'(sweep_x - DEPTH_X) : AW'(sweep_x);
        rd_addr    = cmd.load ? old_addr : sweep_addr;
    end

    // status decodes
    assign need_dev   = idx_reg > INDEX_W'(len_eff);
    assign drop_old   = idx_reg >= INDEX_W'(len_eff);
    assign sweep_last = (INDEX_W'(k_reg) == idx_reg) || (k_reg == len_eff - 1'b1);

    assign status.resync     = resync_reg;
    assign status.need_dev   = need_dev;
    assign status.sweep_last = sweep_last;
    assign status.out_full   = out_valid_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = sample_reg;
        mul_b = MULB_W'(sample_reg);
        if (cmd.upd_sq || cmd.sw_sq)
        begin
            mul_a = rd_data_reg;
            mul_b = MULB_W'(rd_data_reg);
        end
        else if (cmd.mul_dev)
        begin
            mul_a = div_quo_reg[SAMPLE_W-1:0];
            mul_b = MULB_W'(sum_reg) + MULB_W'(div_rem_reg[LEN_W-1:0]);
        end
        mul_p = SQ_SUM_W'(33'(mul_a) * 33'(mul_b));
    end

    // restoring divider step
    always_comb
    begin
        div_shift = {div_rem_reg[LEN_W-1:0], div_quo_reg[SUM_W-1]};
        div_bit   = div_shift >= {1'b0, len_eff};
    end

    // square root step, two radicand bits per cycle
    always_comb
    begin
        rem_shift  = {root_rem_reg[VALUE_W-1:0], root_x_reg[SQ_SUM_W-1 -: 2]};
        root_trial = {root_reg, 2'b01};
        root_bit   = rem_shift >= root_trial;
    end

    // running sum bases restart at the first word of a frame
    assign sum_base = (idx_reg == '0) ? '0 : sum_reg;
    assign sq_base  = (idx_reg == '0) ? '0 : sq_sum_reg;

    // sample ring, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            ring_mem[pos_reg] <= sample_reg;
        if (cmd.load || cmd.sw_rd)
            rd_data_reg <= ring_mem[rd_addr];
    end

    // control state and window sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg  <= LEN_RESET;
            resync_reg      <= 1'b0;
            pixel_count_reg <= '0;
            pos_reg         <= '0;
            sum_reg         <= '0;
            sq_sum_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_len_reg <= cfg_wdata;
                resync_reg     <= 1'b1;
            end
            else if (cmd.sw_acc && sweep_last)
                resync_reg <= 1'b0;

            if (cmd.capture)
                pixel_count_reg <= (idx_in >= LAST_IDX) ? '0 : idx_in + 1'b1;

            if (cmd.load)
                pos_reg <= (pos_reg == AW'(MAX_WINDOW - 1)) ? '0 : pos_reg + 1'b1;

            if (cmd.load && resync_reg)
            begin
                sum_reg    <= '0;
                sq_sum_reg <= '0;
            end
            else if (cmd.upd_acc)
            begin
                sum_reg    <= sum_base + SUM_W'(sample_reg)
                              - (drop_old ? SUM_W'(rd_data_reg) : '0);
                sq_sum_reg <= sq_base + SQ_SUM_W'(sq_new_reg)
                              - (drop_old ? prod_reg : '0);
            end
            else if (cmd.sw_acc)
            begin
                sum_reg    <= sum_reg + SUM_W'(rd_data_reg);
                sq_sum_reg <= sq_sum_reg + prod_reg;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // per word working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= in_sample;
            idx_reg    <= idx_in;
        end

        if (cmd.load)
        begin
            cur_pos_reg <= pos_reg;
            sq_new_reg  <= mul_p[SQ_W-1:0];
            k_reg       <= '0;
        end

        if (cmd.upd_sq || cmd.sw_sq || cmd.mul_dev)
            prod_reg <= mul_p;

        if (cmd.sw_acc)
            k_reg <= k_reg + 1'b1;

        if (cmd.prep)
        begin
            div_quo_reg <= sum_reg;
            div_rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_bit ? div_shift - {1'b0, len_eff} : div_shift;
            div_quo_reg <= {div_quo_reg[SUM_W-2:0], div_bit};
        end

        if (cmd.sub)
        begin
            root_x_reg   <= sq_sum_reg - prod_reg;
            root_rem_reg <= '0;
            root_reg     <= '0;
        end
        else if (cmd.root_step)
        begin
            root_x_reg   <= {root_x_reg[SQ_SUM_W-3:0], 2'b00};
            root_rem_reg <= root_bit ? rem_shift - root_trial : rem_shift;
            root_reg     <= {root_reg[VALUE_W-2:0], root_bit};
        end

        if (cmd.out_load)
        begin
            out_value_reg  <= need_dev ? root_reg : VALUE_W'(sample_reg);
            out_is_dev_reg <= need_dev;
            out_index_reg  <= idx_reg;
            out_last_reg   <= idx_reg == LAST_IDX;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_is_dev = out_is_dev_reg;
    assign out_index  = out_index_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

[hw/rtl/sliding_window_deviation.sv]
// Sliding window deviation over 12-bit pixel words. For each pixel whose index in the frame
// is above the window length it returns the floor square root of the summed squared
// deviations of the last window_len samples from their floored mean; earlier pixels pass
// the raw sample through. The block takes one word at a time; the deviation path runs a restoring
// divider for the mean and a square root, one step per cycle each, with one shared 12x21
// multiplier. The window sums run incrementally from a sample ring with one write and one read
// port; after a write to window_len the next word rebuilds them instead with a sweep that reads,
// squares and accumulates each window entry in turn. Depends on swd_pkg, swd_ctrl and swd_datapath.
`default_nettype none

module sliding_window_deviation #(
    parameter int FRAME_PIXELS = 4096,
    parameter int MAX_WINDOW   = 256
) (
    input  wire         clk,
    input  wire         rst_n,
    // window length register
    input  wire         cfg_we,
    input  wire  [7:0]  cfg_wdata,
    // input words
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  wire         s_tuser,   // [0] frame_start
    // result words
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [15:0] value, [27:16] pixel_index, [31:28] zero
    output logic        m_tuser,   // [0] is_deviation
    output logic        m_tlast
);
    import swd_pkg::*;

    swd_cmd_t            cmd;
    swd_status_t         status;
    logic [VALUE_W-1:0]  out_value;
    logic [INDEX_W-1:0]  out_index;

    // sequencer
    swd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    swd_datapath #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_sample      (s_tdata[SAMPLE_W-1:0]),
        .in_frame_start (s_tuser),
        .cmd            (cmd),
        .status         (status),
        .m_tready       (m_tready),
        .out_valid      (m_tvalid),
        .out_value      (out_value),
        .out_is_dev     (m_tuser),
        .out_index      (out_index),
        .out_last       (m_tlast)
    );

    // result word packing
    assign m_tdata = {{(M_TDATA_W - VALUE_W - INDEX_W){1'b0}}, out_index, out_value};

endmodule

`default_nettype wire

[hw/rtl/swd_checker.sv]
// port level checks for the sliding window deviation block
// uses the macros of sliding_window_deviation_defines.svh; bound to the top level
`default_nettype none

`include "sliding_window_deviation_defines.svh"

module swd_checker #(
    parameter int FRAME_PIXELS = 4096
) (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire        m_tuser,
    input wire        m_tlast
);

    // a stalled result word holds
    `SWD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // one word at a time: busy right after an accept
    `SWD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input accepted while a word is in work")

    // a passed-through sample stays within 12 bits
    `SWD_ASSERT_NOW(a_raw_range, m_tvalid && !m_tuser, m_tdata[15:12] == 4'd0, "raw sample wider than 12 bits")

    // a deviation needs more pixels than the shortest window
    `SWD_ASSERT_NOW(a_dev_index, m_tvalid && m_tuser, m_tdata[27:16] > 12'd1, "deviation on too early a pixel")

    // the last marker sits on the last pixel index of the frame
    `SWD_ASSERT_NOW(a_last_index, m_tvalid && m_tlast, m_tdata[27:16] == 12'(FRAME_PIXELS - 1), "frame last on wrong index")

endmodule

bind sliding_window_deviation swd_checker #(
    .FRAME_PIXELS (FRAME_PIXELS)
) u_swd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
